// ===== hdl/alt_pkg.sv =====
`timescale 1ns / 1ps

package alt_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // Character codes used by the tokenizer.
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;

  typedef enum logic [2:0] {
    PmBetween,
    PmUnquoted,
    PmQuoted,
    PmComment,
    PmDrop
  } parse_mode_e;

  typedef enum logic [2:0] {
    EmNone,
    EmSlash,
    EmHex1,
    EmHex2,
    EmOctal
  } esc_mode_e;

  typedef enum logic [1:0] {
    SepNone,
    SepSpace,
    SepComma,
    SepQuote
  } sep_e;

  typedef enum logic [1:0] {
    KindByte,
    KindEndArg,
    KindEndLine,
    KindError
  } kind_e;

  typedef enum logic [1:0] {
    ErrEscape,
    ErrStray,
    ErrMissQuote,
    ErrMissSep
  } err_e;

  typedef enum logic [1:0] {
    CfgCommaSep,
    CfgComment,
    CfgNoEscapes
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [1:0] error_code;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic comma_separates;
    logic comment_enabled;
    logic no_escapes;
  } cfg_t;

  typedef out_item_t [MaxResults-1:0] out_arr_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    out_arr_t        items;
  } step_res_t;

endpackage

// ===== hdl/alt_step.sv =====
`timescale 1ns / 1ps

module alt_step import alt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      take_i,
  input  in_item_t  item_i,
  output step_res_t res_o
);

  parse_mode_e pm_q, pm_d;
  esc_mode_e   em_q, em_d;
  logic [7:0]  ev_q, ev_d;
  logic [1:0]  ed_q, ed_d;
  sep_e        ls_q, ls_d;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || (c >= ChLowA && c <= ChLowF) ||
           (c >= ChUpA && c <= ChUpF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= ChNine) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  always_comb begin
    logic [7:0]      c;
    logic            do_plain;
    logic            go;
    logic            skip;
    logic [CntW-1:0] n;
    out_arr_t        res;

    c        = item_i.char_in;
    pm_d     = pm_q;
    em_d     = em_q;
    ev_d     = ev_q;
    ed_d     = ed_q;
    ls_d     = ls_q;
    n        = '0;
    res      = '0;
    do_plain = 1'b0;
    go       = 1'b0;
    skip     = 1'b0;

    if (pm_q == PmUnquoted || pm_q == PmQuoted) begin
      case (em_q)
        EmNone: begin
          do_plain = 1'b1;
        end
        EmSlash: begin
          em_d = EmNone;
          if (c == ChLowN) begin
            res[n].char_out = ChLf;
            n = n + 1'b1;
          end else if (c == ChLowR) begin
            res[n].char_out = ChCr;
            n = n + 1'b1;
          end else if (c == ChLowT) begin
            res[n].char_out = ChTab;
            n = n + 1'b1;
          end else if (c == ChQuote || c == ChBslash) begin
            res[n].char_out = c;
            n = n + 1'b1;
          end else if (c >= ChZero && c <= ChSeven) begin
            em_d = EmOctal;
            ev_d = {5'd0, c[2:0]};
            ed_d = 2'd1;
          end else if (c == ChLowX) begin
            em_d = EmHex1;
          end else begin
            res[n].kind       = KindError;
            res[n].error_code = ErrEscape;
            n = n + 1'b1;
            pm_d = PmDrop;
          end
        end
        EmHex1: begin
          if (!is_hex(c)) begin
            res[n].kind       = KindError;
            res[n].error_code = ErrEscape;
            n = n + 1'b1;
            pm_d = PmDrop;
            em_d = EmNone;
          end else begin
            ev_d = {4'd0, hex_val(c)};
            em_d = EmHex2;
          end
        end
        EmHex2: begin
          em_d = EmNone;
          if (!is_hex(c)) begin
            res[n].kind       = KindError;
            res[n].error_code = ErrEscape;
            n = n + 1'b1;
            pm_d = PmDrop;
          end else begin
            res[n].char_out = {ev_q[3:0], hex_val(c)};
            n = n + 1'b1;
          end
        end
        EmOctal: begin
          em_d = EmNone;
          if (c >= ChZero && c <= ChSeven && ed_q != 2'd3) begin
            ev_d = {ev_q[4:0], c[2:0]};
            ed_d = ed_q + 2'd1;
            if (ed_d == 2'd3) begin
              res[n].char_out = ev_d;
              n = n + 1'b1;
            end else begin
              em_d = EmOctal;
            end
          end else begin
            res[n].char_out = ev_q;
            n = n + 1'b1;
            do_plain = 1'b1;
          end
        end
        default: begin
          em_d     = EmNone;
          do_plain = 1'b1;
        end
      endcase
    end else if (pm_q == PmBetween) begin
      em_d     = EmNone;
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (pm_d == PmBetween) begin
        if (is_space(c)) begin
          go = 1'b0;
        end else if (ls_d == SepSpace && c == ChComma && cfg_i.comma_separates) begin
          ls_d = SepNone;
        end else if (ls_d == SepQuote && c == ChQuote) begin
          res[n].kind       = KindError;
          res[n].error_code = ErrMissSep;
          n = n + 1'b1;
          pm_d = PmDrop;
          em_d = EmNone;
        end else begin
          ls_d = SepNone;
          if (cfg_i.comment_enabled && c == ChHash) begin
            pm_d = PmComment;
          end else if (c == ChQuote && !cfg_i.no_escapes) begin
            pm_d = PmQuoted;
          end else begin
            pm_d = PmUnquoted;
            go   = 1'b1;
          end
        end
      end else begin
        go = 1'b1;
      end

      if (go) begin
        if (pm_d == PmUnquoted) begin
          if (c == ChBslash && !cfg_i.no_escapes) begin
            em_d = EmSlash;
          end else if (is_space(c)) begin
            res[n].kind = KindEndArg;
            n = n + 1'b1;
            ls_d = SepSpace;
            pm_d = PmBetween;
          end else if (cfg_i.comma_separates && c == ChComma) begin
            res[n].kind = KindEndArg;
            n = n + 1'b1;
            ls_d = SepComma;
            pm_d = PmBetween;
          end else if (!cfg_i.no_escapes && c == ChQuote) begin
            res[n].kind       = KindError;
            res[n].error_code = ErrStray;
            n = n + 1'b1;
            pm_d = PmDrop;
            em_d = EmNone;
          end else begin
            res[n].char_out = c;
            n = n + 1'b1;
          end
        end else if (pm_d == PmQuoted) begin
          if (c == ChBslash && !cfg_i.no_escapes) begin
            em_d = EmSlash;
          end else if (c == ChQuote && !cfg_i.no_escapes) begin
            res[n].kind = KindEndArg;
            n = n + 1'b1;
            ls_d = SepQuote;
            pm_d = PmBetween;
          end else begin
            res[n].char_out = c;
            n = n + 1'b1;
          end
        end
      end
    end

    // The last byte closes out the line and returns to the idle state.
    if (item_i.line_end) begin
      if (pm_d != PmDrop) begin
        if (em_d == EmOctal) begin
          res[n].char_out = ev_d;
          n = n + 1'b1;
        end else if (em_d != EmNone) begin
          res[n].kind       = KindError;
          res[n].error_code = ErrEscape;
          n = n + 1'b1;
          skip = 1'b1;
        end
        if (!skip) begin
          if (pm_d == PmUnquoted) begin
            res[n].kind = KindEndArg;
            n = n + 1'b1;
          end else if (pm_d == PmQuoted) begin
            res[n].kind       = KindError;
            res[n].error_code = ErrMissQuote;
            n = n + 1'b1;
            skip = 1'b1;
          end else if (pm_d == PmBetween && ls_d == SepComma) begin
            res[n].kind = KindEndArg;
            n = n + 1'b1;
          end
        end
        if (!skip) begin
          res[n].kind = KindEndLine;
          n = n + 1'b1;
        end
      end
      pm_d = PmBetween;
      em_d = EmNone;
      ev_d = '0;
      ed_d = '0;
      ls_d = SepNone;
    end

    for (int i = 0; i < MaxResults; i++) begin
      res[i].run_last = (CntW'(i + 1) == n);
    end

    res_o.count = n;
    res_o.items = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= PmBetween;
      em_q <= EmNone;
      ev_q <= '0;
      ed_q <= '0;
      ls_q <= SepNone;
    end else if (take_i) begin
      pm_q <= pm_d;
      em_q <= em_d;
      ev_q <= ev_d;
      ed_q <= ed_d;
      ls_q <= ls_d;
    end
  end

endmodule

// ===== hdl/alt_rbuf.sv =====
`timescale 1ns / 1ps

module alt_rbuf import alt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  step_res_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  out_arr_t        items_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] idx_q;
  logic            fire;

  assign out_valid_o = (idx_q != cnt_q);
  assign fire        = out_valid_o && out_ready_i;
  // Free when empty, or when the last held result leaves in this cycle.
  assign free_o      = !out_valid_o || (fire && (idx_q + 1'b1 == cnt_q));
  assign out_data_o  = items_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i && free_o) begin
      cnt_q <= res_i.count;
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      items_q <= res_i.items;
    end
  end

endmodule

// ===== hdl/argument_line_tokenizer.sv =====
`timescale 1ns / 1ps

// Shell-style argument tokenizer with backslash escapes.
// Input channel: one byte of the command line per transfer, line_end set on
// the last byte. Output channel: one result per transfer, kind giving an
// argument byte, end of argument, end of line or error, with run_last on
// the last result caused by an input byte. A byte may cause zero to five
// results. Configuration channel: index 0 comma_separates, 1 comment_enabled,
// 2 no_escapes; bit 0 of the data is written, other indexes are ignored.
// Write it only while the block is idle.
// A byte is held in an input register, decoded combinationally against the
// line state, and its results are loaded into a result buffer that offers
// them one at a time. The block takes one byte per cycle while each byte
// yields at most one result and the receiver is ready; a byte with k results
// holds the input until all k have left through the single output port.
// When the receiver stalls, the result buffer and input register fill and
// in_ready_o drops. Reset zeroes line state, config and valid flags, not data.
module argument_line_tokenizer import alt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic      cfg_data_i
);

  cfg_t      cfg_q;
  in_item_t  in_q;
  logic      in_vld_q;
  logic      buf_free;
  logic      take;
  step_res_t step_res;

  assign cfg_ready_o = 1'b1;
  assign take        = in_vld_q && buf_free;
  assign in_ready_o  = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgCommaSep:  cfg_q.comma_separates <= cfg_data_i;
        CfgComment:   cfg_q.comment_enabled <= cfg_data_i;
        CfgNoEscapes: cfg_q.no_escapes      <= cfg_data_i;
        default:      cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  alt_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .take_i (take),
    .item_i (in_q),
    .res_o  (step_res)
  );

  alt_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (step_res),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import alt_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 150;
  localparam int DrainCycles   = 8;
  localparam int RandomBytes   = 80;
  localparam int PhaseBytes    = 20;
  localparam int MaxReported   = 10;
  localparam logic [1:0] CfgSpare = 2'd3;  // unmapped register index
  localparam logic [4:0] HexBad   = 5'h10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic      cfg_data_i;

  argument_line_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow of the tokenizer's registers and line state.
  cfg_t        cfg_shadow;
  parse_mode_e tok_mode;
  esc_mode_e   esc_state;
  logic [7:0]  esc_acc;
  logic [1:0]  esc_ndig;
  sep_e        prev_sep;

  out_item_t step_results[$];
  out_item_t pending_results[$];
  logic [7:0] line_buf[$];

  int  n_bytes;
  int  n_lines;
  int  n_results;
  int  n_settings;
  int  n_mismatch;
  bit  tx_no_gap;
  bit  hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_ws(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return {1'b0, c[3:0]};
    if (c >= ChLowA && c <= ChLowF) return 5'(c - ChLowA + 8'd10);
    if (c >= ChUpA && c <= ChUpF) return 5'(c - ChUpA + 8'd10);
    return HexBad;
  endfunction

  task automatic clear_line_state();
    tok_mode  = PmBetween;
    esc_state = EmNone;
    esc_acc   = '0;
    esc_ndig  = '0;
    prev_sep  = SepNone;
  endtask

  task automatic emit(kind_e k, logic [7:0] ch, logic [1:0] code);
    out_item_t r;
    if (step_results.size() < MaxResults) begin
      r.kind       = k;
      r.char_out   = ch;
      r.error_code = code;
      r.run_last   = 1'b0;
      step_results.push_back(r);
    end
  endtask

  task automatic raise_error(err_e code);
    emit(KindError, '0, code);
    tok_mode  = PmDrop;
    esc_state = EmNone;
  endtask

  task automatic take_plain(logic [7:0] c);
    if (tok_mode == PmBetween) begin
      if (is_ws(c)) return;
      // When commas separate, a comma after a whitespace-ended argument is only a separator.
      if (prev_sep == SepSpace && c == ChComma && cfg_shadow.comma_separates) begin
        prev_sep = SepNone;
        return;
      end
      if (prev_sep == SepQuote && c == ChQuote) begin
        raise_error(ErrMissSep);
        return;
      end
      prev_sep = SepNone;
      if (cfg_shadow.comment_enabled && c == ChHash) begin
        tok_mode = PmComment;
        return;
      end
      if (c == ChQuote && !cfg_shadow.no_escapes) begin
        tok_mode = PmQuoted;
        return;
      end
      tok_mode = PmUnquoted;
    end
    if (tok_mode == PmUnquoted) begin
      if (c == ChBslash && !cfg_shadow.no_escapes) begin
        esc_state = EmSlash;
      end else if (is_ws(c)) begin
        emit(KindEndArg, '0, '0);
        prev_sep = SepSpace;
        tok_mode = PmBetween;
      end else if (cfg_shadow.comma_separates && c == ChComma) begin
        emit(KindEndArg, '0, '0);
        prev_sep = SepComma;
        tok_mode = PmBetween;
      end else if (!cfg_shadow.no_escapes && c == ChQuote) begin
        raise_error(ErrStray);
      end else begin
        emit(KindByte, c, '0);
      end
    end else if (tok_mode == PmQuoted) begin
      if (c == ChBslash && !cfg_shadow.no_escapes) begin
        esc_state = EmSlash;
      end else if (c == ChQuote && !cfg_shadow.no_escapes) begin
        emit(KindEndArg, '0, '0);
        prev_sep = SepQuote;
        tok_mode = PmBetween;
      end else begin
        emit(KindByte, c, '0);
      end
    end
  endtask

  // Consumes a byte of a pending escape; again is set when the byte must
  // also go through the plain path (it ended an octal escape).
  task automatic take_escape(logic [7:0] c, output logic again);
    logic [4:0] h;
    again = 1'b0;
    case (esc_state)
      EmSlash: begin
        esc_state = EmNone;
        if (c == ChLowN) emit(KindByte, ChLf, '0);
        else if (c == ChLowR) emit(KindByte, ChCr, '0);
        else if (c == ChLowT) emit(KindByte, ChTab, '0);
        else if (c == ChQuote || c == ChBslash) emit(KindByte, c, '0);
        else if (is_octal(c)) begin
          esc_state = EmOctal;
          esc_acc   = {5'b0, c[2:0]};
          esc_ndig  = 2'd1;
        end else if (c == ChLowX) esc_state = EmHex1;
        else raise_error(ErrEscape);
      end
      EmHex1: begin
        h = hex_nibble(c);
        if (h == HexBad) raise_error(ErrEscape);
        else begin
          esc_acc   = {4'b0, h[3:0]};
          esc_state = EmHex2;
        end
      end
      EmHex2: begin
        h = hex_nibble(c);
        if (h == HexBad) raise_error(ErrEscape);
        else begin
          emit(KindByte, {esc_acc[3:0], h[3:0]}, '0);
          esc_state = EmNone;
        end
      end
      EmOctal: begin
        if (is_octal(c) && esc_ndig < 2'd3) begin
          esc_acc  = {esc_acc[4:0], c[2:0]};
          esc_ndig = esc_ndig + 2'd1;
          if (esc_ndig == 2'd3) begin
            emit(KindByte, esc_acc, '0);
            esc_state = EmNone;
          end
        end else begin
          emit(KindByte, esc_acc, '0);
          esc_state = EmNone;
          again     = 1'b1;
        end
      end
      default: begin
        esc_state = EmNone;
        again     = 1'b1;
      end
    endcase
  endtask

  task automatic close_line();
    if (tok_mode == PmDrop) return;
    if (esc_state == EmOctal) begin
      emit(KindByte, esc_acc, '0);
      esc_state = EmNone;
    end else if (esc_state != EmNone) begin
      raise_error(ErrEscape);
      return;
    end
    if (tok_mode == PmUnquoted) begin
      emit(KindEndArg, '0, '0);
    end else if (tok_mode == PmQuoted) begin
      raise_error(ErrMissQuote);
      return;
    end else if (tok_mode == PmBetween && prev_sep == SepComma) begin
      emit(KindEndArg, '0, '0);
    end
    emit(KindEndLine, '0, '0);
  endtask

  task automatic predict_tokens(logic [7:0] c, logic last);
    logic again;
    again = 1'b1;
    step_results.delete();
    if (tok_mode == PmUnquoted || tok_mode == PmQuoted) begin
      if (esc_state != EmNone) take_escape(c, again);
      if (again) take_plain(c);
    end else if (tok_mode == PmBetween) begin
      esc_state = EmNone;
      take_plain(c);
    end
    if (last) begin
      close_line();
      clear_line_state();
    end
    if (step_results.size() > 0) step_results[$].run_last = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_result(string what, out_item_t want, out_item_t got);
    n_mismatch++;
    if (n_mismatch <= MaxReported) begin
      $display("%0t %s: expected kind=%0d char=%02h err=%0d last=%0b",
               $time, what, want.kind, want.char_out, want.error_code, want.run_last);
      $display("%0t %s: got      kind=%0d char=%02h err=%0d last=%0b",
               $time, what, got.kind, got.char_out, got.error_code, got.run_last);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_result("unexpected result", '0, out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.kind !== want.kind || out_data_o.char_out !== want.char_out ||
            out_data_o.error_code !== want.error_code ||
            out_data_o.run_last !== want.run_last)
          report_result("result mismatch", want, out_data_o);
      end
    end
  end

  // Receiver: random ready pattern, with a long hold-off on request.
  initial begin : drive_ready
    int   run_left;
    int   r;
    logic rdy;
    run_left    = 0;
    rdy         = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        run_left = 0;
      end
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          rdy = 1'b1; run_left = $urandom_range(20, 60);
        end else if (r < 60) begin
          rdy = 1'b1; run_left = $urandom_range(1, 6);
        end else if (r < 92) begin
          rdy = 1'b0; run_left = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0; run_left = $urandom_range(10, 40);
        end
      end
      out_ready_i <= rdy;
      run_left--;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle = 0;
      else
        idle++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results still expected",
             WatchdogLimit, pending_results.size());
    $display("argument_line_tokenizer verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_byte(logic [7:0] c, logic last);
    int       gap;
    in_item_t item;
    gap = tx_no_gap ? 0 : pick_gap();
    item.char_in  = c;
    item.line_end = last;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predict_tokens(c, last);
    n_bytes++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    n_lines++;
  endtask

  task automatic send_text(string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  // Waits until every expected result has been seen and the block is quiet.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    case (cfg_idx_e'(idx))
      CfgCommaSep:  cfg_shadow.comma_separates = v;
      CfgComment:   cfg_shadow.comment_enabled = v;
      CfgNoEscapes: cfg_shadow.no_escapes      = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic comma, logic comment, logic raw);
    settle();
    write_reg(CfgCommaSep, comma);
    write_reg(CfgComment, comment);
    write_reg(CfgNoEscapes, raw);
    n_settings++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return ChZero + 8'(v);
    return ($urandom_range(0, 1) ? ChLowA : ChUpA) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 11))
      0: return ChQuote;
      1: return ChBslash;
      2: return ChComma;
      3: return ChSpace;
      4: return ChHash;
      5: return ChLowX;
      6: return ChZero + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_escape();
    int n;
    line_buf.push_back(ChBslash);
    case ($urandom_range(0, 9))
      0: line_buf.push_back(ChLowN);
      1: line_buf.push_back(ChLowR);
      2: line_buf.push_back(ChLowT);
      3: line_buf.push_back(ChQuote);
      4: line_buf.push_back(ChBslash);
      5, 6: begin
        n = $urandom_range(1, 3);
        repeat (n) line_buf.push_back(ChZero + 8'($urandom_range(0, 7)));
      end
      7, 8: begin
        line_buf.push_back(ChLowX);
        line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
        line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      default: begin
        // Malformed escape: unknown letter or a non-hex digit after x.
        if ($urandom_range(0, 1)) begin
          line_buf.push_back("q");
        end else begin
          line_buf.push_back(ChLowX);
          line_buf.push_back("g");
        end
      end
    endcase
  endtask

  task automatic add_word();
    int n;
    int r;
    n = $urandom_range(1, 4);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 6) line_buf.push_back(ChLowA + 8'($urandom_range(0, 25)));
      else if (r < 7) line_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
      else if (r < 8) line_buf.push_back(8'($urandom_range(128, 255)));
      else add_escape();
    end
  endtask

  task automatic add_separator();
    case ($urandom_range(0, 5))
      0, 1: line_buf.push_back(ChSpace);
      2: line_buf.push_back(ChTab);
      3: line_buf.push_back(ChComma);
      4: begin
        line_buf.push_back(ChSpace);
        line_buf.push_back(ChComma);
      end
      default: line_buf.push_back(8'($urandom_range(10, 13)));
    endcase
  endtask

  task automatic add_arg();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: add_word();
      5, 6, 7: begin
        line_buf.push_back(ChQuote);
        n = $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) line_buf.push_back(noise_byte() == ChQuote ?
                                                            ChSpace : ChComma);
          else add_word();
        end
        if ($urandom_range(0, 9) != 0) line_buf.push_back(ChQuote);
      end
      8: begin
        line_buf.push_back(ChHash);
        add_word();
      end
      default: add_escape();
    endcase
  endtask

  // Mostly well-formed argument lists with random content, some noise.
  task automatic make_line();
    int n;
    line_buf.delete();
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 10);
      repeat (n) line_buf.push_back(noise_byte());
    end else begin
      n = $urandom_range(1, 3);
      for (int a = 0; a < n; a++) begin
        if (a > 0 || $urandom_range(0, 3) == 0) add_separator();
        add_arg();
      end
      if ($urandom_range(0, 3) == 0) add_separator();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_whitespace_and_escapes();
    line_buf.delete();
    for (int i = 0; i < 6; i++) begin
      line_buf.push_back(ChLowA + 8'(i));
      line_buf.push_back(i < 5 ? ChTab + 8'(i) : ChSpace);
    end
    line_buf.push_back("z");
    send_line();
    send_text("\"q\\n\\r\\t\\\"\\\\\"");
    send_text("\\101\\7x\\377\\777\\1");
    send_text("\\x4F\\xaf");
    line_buf = '{8'h00, 8'hff, ChSpace, 8'h80, 8'h7f};
    send_line();
    send_text("#x,");
  endtask

  task automatic test_error_cases();
    send_text("ab\\q");
    send_text("\\x4g z");
    send_text("\\x0");
    send_text("ab\\");
    send_text("ab\"c d");
    send_text("\"abc");
    send_text("\"a\" \"b\"");
    send_text("\"a\"b");
  endtask

  task automatic test_separators_and_comments();
    set_config(1'b1, 1'b1, 1'b0);
    send_text("a,b ,c,");
    send_text("\"x\",y");
    send_text("a #b c");
    send_text("#");
    set_config(1'b1, 1'b1, 1'b1);
    send_text("a,\"b\\# c");
  endtask

  task automatic test_raw_mode();
    set_config(1'b0, 1'b0, 1'b1);
    send_text("\"a\\b\" c\\");
    // The spare index must not disturb any register.
    settle();
    write_reg(CfgSpare, 1'b1);
    send_text("\"x\" ,");
    set_config(1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    int start;
    set_config(1'b1, 1'b0, 1'b0);
    tx_no_gap    = 1'b1;
    hold_off_req = 1'b1;
    start        = n_bytes;
    while (n_bytes - start < 40) begin
      make_line();
      send_line();
    end
    tx_no_gap = 1'b0;
    settle();
  endtask

  task automatic test_random_lines();
    int start;
    int phase_start;
    start = n_bytes;
    while (n_bytes - start < RandomBytes) begin
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3) == 0);
      phase_start = n_bytes;
      while (n_bytes - phase_start < PhaseBytes) begin
        make_line();
        send_line();
      end
    end
  endtask

  initial begin : run_tests
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = 1'b0;
    tx_no_gap    = 1'b0;
    hold_off_req = 1'b0;
    n_bytes      = 0;
    n_lines      = 0;
    n_results    = 0;
    n_settings   = 0;
    n_mismatch   = 0;
    cfg_shadow   = '0;
    clear_line_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_whitespace_and_escapes();
    test_error_cases();
    test_separators_and_comments();
    test_raw_mode();
    test_backpressure();
    test_random_lines();

    settle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes in %0d lines under %0d register settings; %0d results checked.",
             n_bytes, n_lines, n_settings, n_results);
    $display("Mismatches: %0d, results never delivered: %0d",
             n_mismatch, pending_results.size());
    if (n_mismatch == 0 && pending_results.size() == 0)
      $display("argument_line_tokenizer verification clean");
    else
      $display("argument_line_tokenizer verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/alt_pkg.sv
hdl/alt_step.sv
hdl/alt_rbuf.sv
hdl/argument_line_tokenizer.sv
sim/tb.sv
